@@ rtl/core/miller_rabin_primality_test_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define MR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define MR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mrpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpt_pkg
// Types and constants shared by the primality test modules.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
    localparam int BIT_WIDTH = $clog2(NUM_WIDTH);

    typedef logic [NUM_WIDTH-1:0] t_num;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,    // latch request, start reduction of the witness
        OP_MUL,     // start one modular multiply
        OP_SHIFT    // strip one trailing zero from d
    } t_op;

    typedef enum logic [1:0] {
        MUL_SQR_B,  // b <= b*b
        MUL_ACC_B,  // x <= x*b
        MUL_SQR_X   // x <= x*x
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        logic  set_fail;
        logic  clr_fail;
        logic  set_x_one;
        logic  exp_shr;
    } t_cmd;

    typedef struct packed {
        logic busy;       // reduction or multiply running
        logic trivial_pass;
        logic trivial_fail;
        logic a_zero;
        logic d_even;
        logic exp_zero;
        logic exp_lsb;
        logic x_is_one;
        logic x_is_nm1;
        logic r_more;     // squarings remain
        logic last;
        logic fail;
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW_STEP,
        ST_POW_WAIT,
        ST_SQR_B_WAIT,
        ST_TEST_X,
        ST_SQR_X_WAIT,
        ST_DONE,
        ST_OUT
    } t_state;

endpackage

@@ rtl/core/mrpt_datapath.sv @@
// ----------------------------------------------------------------------------
// mrpt_datapath
// Operand registers, a bit-serial modular reducer and a double-and-add
// modular multiplier, driven by commands from the controller.
// ----------------------------------------------------------------------------
module mrpt_datapath
    import mrpt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NUM_WIDTH-1:0] i_candidate,
    input  logic [NUM_WIDTH-1:0] i_witness,
    input  logic                i_last,
    input  t_cmd                i_cmd,
    output t_sts                o_sts
);

    t_num                 r_n, r_b, r_x, r_d, r_acc, r_y, r_rem, r_div;
    logic                 r_last, r_fail, r_busy, r_red;
    logic [BIT_WIDTH-1:0] r_bit;
    logic [CNT_WIDTH-1:0] r_r;
    t_msel                r_msel;
    t_num                 n_sum1, n_sum2, n_dbl, n_rem2;
    logic [NUM_WIDTH:0]   w_s1, w_s2, w_rs;

    // Doubling step, then conditional add, both modulo n.
    always_comb begin
        w_s1   = {1'b0, r_acc} + {1'b0, r_acc};
        n_dbl  = (w_s1 >= {1'b0, r_n}) ? NUM_WIDTH'(w_s1 - {1'b0, r_n}) : w_s1[NUM_WIDTH-1:0];
        w_s2   = {1'b0, n_dbl} + {1'b0, (r_msel == MUL_SQR_B) ? r_b : r_x};
        n_sum2 = (w_s2 >= {1'b0, r_n}) ? NUM_WIDTH'(w_s2 - {1'b0, r_n}) : w_s2[NUM_WIDTH-1:0];
        n_sum1 = r_y[r_bit] ? n_sum2 : n_dbl;
        // Restoring remainder step: shift in one witness bit.
        w_rs   = {r_rem, r_div[r_bit]};
        n_rem2 = (w_rs >= {1'b0, r_n}) ? NUM_WIDTH'(w_rs - {1'b0, r_n}) : w_rs[NUM_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
            r_busy <= 1'b0;
            r_red  <= 1'b0;
        end else begin
            if (i_cmd.set_fail) r_fail <= 1'b1;
            if (i_cmd.clr_fail) r_fail <= 1'b0;
            if (i_cmd.set_x_one) r_x <= NUM_WIDTH'(1);
            if (i_cmd.exp_shr) r_d <= r_d >> 1;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_n    <= i_candidate;
                    r_div  <= i_witness;
                    r_last <= i_last;
                    r_d    <= i_candidate - NUM_WIDTH'(1);
                    r_r    <= '0;
                    r_rem  <= '0;
                    r_bit  <= BIT_WIDTH'(NUM_WIDTH - 1);
                    r_red  <= 1'b1;
                    r_busy <= 1'b1;
                end
                OP_SHIFT: begin
                    r_d <= r_d >> 1;
                    r_r <= r_r + CNT_WIDTH'(1);
                end
                OP_MUL: begin
                    r_msel <= i_cmd.msel;
                    r_acc  <= '0;
                    r_y    <= (i_cmd.msel == MUL_SQR_X) ? r_x : r_b;
                    r_bit  <= BIT_WIDTH'(NUM_WIDTH - 1);
                    r_busy <= 1'b1;
                end
                default: begin
                    if (r_busy) begin
                        if (r_red) r_rem <= n_rem2;
                        else       r_acc <= n_sum1;
                        if (r_bit == '0) begin
                            r_busy <= 1'b0;
                            r_red  <= 1'b0;
                            if (r_red) r_b <= n_rem2;
                            else if (r_msel == MUL_SQR_B) r_b <= n_sum1;
                            else r_x <= n_sum1;
                            if (!r_red && r_msel == MUL_SQR_X && r_r != '0)
                                r_r <= r_r - CNT_WIDTH'(1);
                        end else begin
                            r_bit <= r_bit - BIT_WIDTH'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_sts.busy         = r_busy;
        o_sts.trivial_pass = (r_n == NUM_WIDTH'(2));
        o_sts.trivial_fail = (r_n < NUM_WIDTH'(2)) || (!r_n[0] && r_n != NUM_WIDTH'(2));
        o_sts.a_zero       = (r_b == '0);
        o_sts.d_even       = !r_d[0];
        o_sts.exp_zero     = (r_d == '0);
        o_sts.exp_lsb      = r_d[0];
        o_sts.x_is_one     = (r_x == NUM_WIDTH'(1));
        o_sts.x_is_nm1     = (r_x == r_n - NUM_WIDTH'(1));
        o_sts.r_more       = (r_r > CNT_WIDTH'(1));
        o_sts.last         = r_last;
        o_sts.fail         = r_fail;
    end

endmodule

@@ rtl/core/mrpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrpt_ctrl
// Round sequencer: handshakes, reduction, exponentiation and squarings.
// ----------------------------------------------------------------------------
module mrpt_ctrl
    import mrpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_REDUCE;
            ST_REDUCE: if (!i_sts.busy) n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_sts.fail || i_sts.trivial_pass || i_sts.trivial_fail)
                    n_state = ST_DONE;
                else if (i_sts.a_zero) n_state = ST_DONE;
                else n_state = ST_SPLIT;
            end
            ST_SPLIT:    if (!i_sts.d_even) n_state = ST_POW_STEP;
            ST_POW_STEP: begin
                if (i_sts.exp_zero)     n_state = ST_TEST_X;
                else if (i_sts.exp_lsb) n_state = ST_POW_WAIT;
                else                    n_state = ST_SQR_B_WAIT;
            end
            ST_POW_WAIT:   if (!i_sts.busy) n_state = ST_SQR_B_WAIT;
            ST_SQR_B_WAIT: if (!i_sts.busy) n_state = ST_POW_STEP;
            ST_TEST_X: begin
                if (i_sts.x_is_nm1 || i_sts.x_is_one) n_state = ST_DONE;
                else if (i_sts.r_more) n_state = ST_SQR_X_WAIT;
                else n_state = ST_DONE;
            end
            ST_SQR_X_WAIT: if (!i_sts.busy) n_state = ST_TEST_X;
            ST_DONE: n_state = i_sts.last ? ST_OUT : ST_IDLE;
            ST_OUT:  if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // The first entry to TEST_X tests for 1 and n-1; later entries follow a
    // squaring, where only n-1 passes and a 1 means failure.
    logic r_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq <= 1'b0;
        else if (r_state == ST_CHECK) r_sq <= 1'b0;
        else if (r_state == ST_SQR_X_WAIT) r_sq <= 1'b1;
    end

    always_comb begin
        o_cmd       = '{op: OP_NONE, msel: MUL_SQR_B, default: 1'b0};
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        case (r_state)
            ST_IDLE:   if (i_in_valid) o_cmd.op = OP_LOAD;
            ST_CHECK: begin
                if (!i_sts.fail && i_sts.trivial_fail) o_cmd.set_fail = 1'b1;
                o_cmd.set_x_one = 1'b1;
            end
            ST_SPLIT:  if (i_sts.d_even) o_cmd.op = OP_SHIFT;
            ST_POW_STEP: begin
                if (!i_sts.exp_zero) begin
                    o_cmd.op   = OP_MUL;
                    o_cmd.msel = i_sts.exp_lsb ? MUL_ACC_B : MUL_SQR_B;
                    if (!i_sts.exp_lsb) o_cmd.exp_shr = 1'b1;
                end
            end
            ST_POW_WAIT: if (!i_sts.busy) begin
                o_cmd.op      = OP_MUL;
                o_cmd.msel    = MUL_SQR_B;
                o_cmd.exp_shr = 1'b1;
            end
            ST_TEST_X: begin
                if (i_sts.x_is_nm1 || (i_sts.x_is_one && !r_sq)) begin
                end else if (i_sts.r_more && !i_sts.x_is_one) begin
                    o_cmd.op   = OP_MUL;
                    o_cmd.msel = MUL_SQR_X;
                end else begin
                    o_cmd.set_fail = 1'b1;
                end
            end
            ST_OUT: if (i_out_ready) o_cmd.clr_fail = 1'b1;
            default: ;
        endcase
    end

endmodule

@@ rtl/core/miller_rabin_primality_test.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_primality_test
// One Miller-Rabin round per request; verdict on the last round.
// ----------------------------------------------------------------------------
// channel  | direction | tdata (low bit up)                | tuser / tlast
// s_axis   | in        | candidate[63:0], witness[127:64]  | tlast = last_round
// m_axis   | out       | probably_prime[0], zero fill      | none
//
// A round loads the request and reduces the witness bit by bit, then runs
// modular multiplies (double-and-add, one bit per cycle): a squaring for each
// bit of d, a product for each set bit and up to r-1 squarings of x. Trivial
// candidates and rounds after a failure skip the multiplies after the reduction.
// The verdict holds while m_axis_tready is low; no request is taken until it
// leaves. Reset is synchronous and clears the sequencer and the failure flag.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test
    import mrpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*NUM_WIDTH-1:0] s_axis_tdata,   // candidate, witness
    input  logic                   s_axis_tlast,   // last_round
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata    // probably_prime, zero fill
);

    t_cmd w_cmd;
    t_sts w_sts;

    mrpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mrpt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_candidate(s_axis_tdata[NUM_WIDTH-1:0]),
        .i_witness  (s_axis_tdata[2*NUM_WIDTH-1:NUM_WIDTH]),
        .i_last     (s_axis_tlast),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

    assign m_axis_tdata = {7'b0, ~w_sts.fail};

endmodule

@@ rtl/core/mrpt_checker.sv @@
// ----------------------------------------------------------------------------
// mrpt_checker
// Port-level checks of the primality test block over time.
// ----------------------------------------------------------------------------
`include "miller_rabin_primality_test_defines.svh"

module mrpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    `MR_ASSERT_IMPL(a_one_side, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "request taken while verdict pending")
    `MR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "verdict dropped")
    `MR_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "no work after request")
    `MR_ASSERT_IMPL(a_fill, i_clk, i_rst_n, 1'b1, m_axis_tdata[7:1] == 7'b0, "fill bits set")

endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (.*);

@@ tb/miller_rabin_primality_test_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_tb
// Self-checking bench for the streaming Miller-Rabin round engine.
// A queue of rounds feeds a bursty sender. The verdict of each candidate is
// predicted in the bench with wide modular arithmetic and then compared with
// what the block returns through a receiver that stalls at random.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_tb;
    import mrpt_pkg::*;

    localparam int  CLK_PERIOD = 12;
    localparam int  LIMIT      = 12_000_000;
    localparam int  DRAIN      = 14_000;
    localparam int  HOLD_LEN   = 30_000;

    typedef struct {
        t_num cand;
        t_num wit;
        logic last;
    } t_round;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*NUM_WIDTH-1:0] s_axis_tdata;   // candidate, witness
    logic                   s_axis_tlast;   // last_round
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // probably_prime, zero fill

    t_round round_q[$];
    logic   verdict_q[$];
    logic   seen_failure;
    int     mismatches;
    int     verdicts_seen;
    longint cycles;

    miller_rabin_primality_test i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_num mul_mod(t_num a, t_num b, t_num n);
        logic [2*NUM_WIDTH-1:0] prod;
        prod = {{NUM_WIDTH{1'b0}}, a} * {{NUM_WIDTH{1'b0}}, b};
        return t_num'(prod % {{NUM_WIDTH{1'b0}}, n});
    endfunction

    function automatic logic round_passes(t_num n, t_num w);
        t_num a, d, x, e, b;
        int   r;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        a = w % n;
        if (a == 0) return 1'b1;
        d = n - 1;
        r = 0;
        while (!d[0]) begin
            d = d >> 1;
            r++;
        end
        x = 1;
        b = a;
        e = d;
        while (e != 0) begin
            if (e[0]) x = mul_mod(x, b, n);
            b = mul_mod(b, b, n);
            e = e >> 1;
        end
        if (x == 1 || x == n - 1) return 1'b1;
        for (int i = 1; i < r; i++) begin
            x = mul_mod(x, x, n);
            if (x == n - 1) return 1'b1;
        end
        return 1'b0;
    endfunction

    // The failure flag is sticky across rounds, so later rounds need no work.
    task automatic predict_verdict(t_round rq);
        if (!seen_failure && !round_passes(rq.cand, rq.wit)) seen_failure = 1'b1;
        if (rq.last) begin
            verdict_q.push_back(!seen_failure);
            seen_failure = 1'b0;
        end
    endtask

    task automatic add_round(t_num n, t_num w, logic last);
        t_round rq;
        rq.cand = n;
        rq.wit  = w;
        rq.last = last;
        round_q.push_back(rq);
    endtask

    function automatic t_num rand_num();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_num pick_candidate();
        t_num primes[5] = '{64'd2305843009213693951, 64'd18446744073709551557,
                            64'd4294967291, 64'd1000000007, 64'd2147483647};
        int   kind;
        kind = $urandom_range(0, 99);
        if (kind < 35) return rand_num() | 64'd1;
        if (kind < 55) return primes[$urandom_range(0, 4)];
        if (kind < 70) return t_num'($urandom_range(0, 1000));
        if (kind < 85) return t_num'({$urandom() | 32'd1}) * t_num'({$urandom() | 32'd1});
        return rand_num();
    endfunction

    // Stimulus: directed rounds first, then well-formed random tests.
    initial begin
        t_num n;
        int   rounds;
        int   items;
        add_round(64'd0, 64'd5, 1'b1);
        add_round(64'd1, 64'd1, 1'b1);
        add_round(64'd2, '1, 1'b1);
        add_round(64'd3, 64'd6, 1'b1);              // base reduces to zero
        add_round(64'd3, 64'd2, 1'b1);
        add_round(64'd4, 64'd3, 1'b1);
        add_round('1, 64'd2, 1'b1);                 // all ones, composite
        add_round(64'd18446744073709551557, 64'd2, 1'b0);
        add_round(64'd18446744073709551557, '1, 1'b0);
        add_round(64'd18446744073709551557, 64'd1, 1'b0);
        add_round(64'd18446744073709551557, 64'd18446744073709551556, 1'b1);
        add_round(64'd561, 64'd2, 1'b1);            // Carmichael number
        add_round(64'd2047, 64'd2, 1'b1);           // strong pseudoprime to base 2
        add_round(64'd2047, 64'd2, 1'b0);
        add_round(64'd2047, 64'd3, 1'b1);
        add_round(64'd9, 64'd2, 1'b0);              // failure, then a new candidate
        add_round(64'd7, 64'd3, 1'b1);
        add_round(64'd7, 64'd14, 1'b1);
        add_round(64'd15, 64'd0, 1'b1);
        add_round(64'd2305843009213693951, 64'h5555_5555_5555_5555, 1'b0);
        add_round(64'd2305843009213693951, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        items = 0;
        while (items < 80) begin
            n = pick_candidate();
            rounds = $urandom_range(1, 4);
            for (int i = 0; i < rounds; i++) begin
                if ($urandom_range(0, 9) == 0) add_round(n, t_num'($urandom_range(0, 4)),
                                                        i == rounds - 1);
                else add_round(n, rand_num(), i == rounds - 1);
                items++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: bursts of requests separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin : sender
        logic taken;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= $urandom_range(1, 8);
            gap_left      <= 0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                predict_verdict(round_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 3000)
                                                              : $urandom_range(0, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
                s_axis_tvalid <= 1'b0;
            end else if (s_axis_tvalid) begin
                s_axis_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (round_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {round_q[0].wit, round_q[0].cand};
                s_axis_tlast  <= round_q[0].last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls in some stretches, none in others, and one long hold.
    int  hold_left;
    int  mode_left;
    logic stall_mode;
    logic held_once;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            mode_left     <= 0;
            stall_mode    <= 1'b0;
            held_once     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held_once && verdicts_seen == 3) begin
            held_once     <= 1'b1;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left  <= $urandom_range(16, 256);
                stall_mode <= 1'($urandom_range(0, 1));
            end else begin
                mode_left <= mode_left - 1;
            end
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // Monitor: each verdict against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mismatches    <= 0;
            verdicts_seen <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            verdicts_seen <= verdicts_seen + 1;
            if (verdict_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected verdict %h", m_axis_tdata);
                mismatches <= mismatches + 1;
            end else if (m_axis_tdata !== {7'b0, verdict_q[0]}) begin
                if (mismatches < 10)
                    $display("verdict mismatch: expected %h, got %h",
                             {7'b0, verdict_q[0]}, m_axis_tdata);
                mismatches <= mismatches + 1;
                void'(verdict_q.pop_front());
            end else begin
                void'(verdict_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        seen_failure = 1'b0;
        wait (i_rst_n === 1'b1);
        wait (round_q.size() == 0 && !s_axis_tvalid);
        wait (verdict_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_datapath.sv
rtl/core/mrpt_ctrl.sv
rtl/core/miller_rabin_primality_test.sv
rtl/core/mrpt_checker.sv
tb/miller_rabin_primality_test_tb.sv
